// ===== rtl/hmq_pkg.sv =====
// Shared constants, types and control structs for the min-heap queue.
package hmq_pkg;

  localparam int unsigned CAPACITY = 127;
  localparam int unsigned IDX_W    = $clog2(CAPACITY + 1);
  localparam int unsigned KEY_W    = 32;
  localparam int unsigned COUNT_W  = 7;
  localparam int unsigned STATUS_W = 2;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_REMOVE = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UP,
    S_UP_CMP,
    S_DN_LOAD,
    S_DN,
    S_DN_CMP,
    S_FIN
  } fsm_e;

  // controller -> datapath
  typedef struct packed {
    logic accept;
    logic rd_parent;
    logic rd_kids;
    logic load_dn;
    logic move;
    logic place;
    logic load_out;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic full;
    logic empty;
    logic at_root;
    logic no_kid;
    logic up_gt;
    logic dn_gt;
  } dp_sts_t;

endpackage

// ===== rtl/hmq_ctrl.sv =====
// Sequencer for insert sift-up and remove sift-down, plus output handshake.
module hmq_ctrl
  import hmq_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  input  logic    in_op_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);

  fsm_e state_q, state_d;
  logic out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          if (op_e'(in_op_i) == OP_INSERT) begin
            state_d = sts_i.full ? S_FIN : S_UP;
          end else begin
            state_d = sts_i.empty ? S_FIN : S_DN_LOAD;
          end
        end
      end
      S_UP: begin
        if (sts_i.at_root) begin
          cmd_o.place = 1'b1;
          state_d     = S_FIN;
        end else begin
          cmd_o.rd_parent = 1'b1;
          state_d         = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        if (sts_i.up_gt) begin
          cmd_o.move = 1'b1;
          state_d    = S_UP;
        end else begin
          cmd_o.place = 1'b1;
          state_d     = S_FIN;
        end
      end
      S_DN_LOAD: begin
        cmd_o.load_dn = 1'b1;
        state_d       = S_DN;
      end
      S_DN: begin
        if (sts_i.no_kid) begin
          cmd_o.place = 1'b1;
          state_d     = S_FIN;
        end else begin
          cmd_o.rd_kids = 1'b1;
          state_d       = S_DN_CMP;
        end
      end
      S_DN_CMP: begin
        if (sts_i.dn_gt) begin
          cmd_o.move = 1'b1;
          state_d    = S_DN;
        end else begin
          cmd_o.place = 1'b1;
          state_d     = S_FIN;
        end
      end
      S_FIN: begin
        // wait until the output register is free or being drained
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== rtl/hmq_dp.sv =====
// Heap store, moving key, position and count registers, compares, result register.
module hmq_dp
  import hmq_pkg::*;
(
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  dp_cmd_t                    cmd_i,
  output dp_sts_t                    sts_o,
  input  logic                       in_op_i,
  input  logic signed [KEY_W-1:0]    in_key_i,
  output logic signed [KEY_W-1:0]    out_min_key_o,
  output logic        [STATUS_W-1:0] out_status_o,
  output logic        [COUNT_W-1:0]  out_count_o
);

  logic        [KEY_W-1:0] mem_q [CAPACITY+1];
  logic signed [KEY_W-1:0] rd_a_q, rd_b_q;
  logic signed [KEY_W-1:0] key_q, min_q;
  logic        [IDX_W-1:0] count_q, pos_q;
  logic                    del_q;
  status_e                 status_q;

  logic signed [KEY_W-1:0]    out_min_q;
  logic        [STATUS_W-1:0] out_status_q;
  logic        [COUNT_W-1:0]  out_count_q;

  logic [IDX_W:0]          kid, kid_p1;
  logic                    pick_right;
  logic [IDX_W-1:0]        pick_idx;
  logic signed [KEY_W-1:0] pick_val;
  logic                    re;
  logic [IDX_W-1:0]        raddr_a, raddr_b;
  logic                    we;
  logic signed [KEY_W-1:0] wdata;
  logic [IDX_W-1:0]        parent;

  assign kid    = {pos_q, 1'b0};
  assign kid_p1 = kid + (IDX_W+1)'(1);
  assign parent = pos_q >> 1;

  // smaller child; right only when left is strictly larger
  assign pick_right = (kid_p1 <= {1'b0, count_q}) && (rd_a_q > rd_b_q);
  assign pick_val   = pick_right ? rd_b_q : rd_a_q;
  assign pick_idx   = pick_right ? kid_p1[IDX_W-1:0] : kid[IDX_W-1:0];

  assign sts_o.full    = (count_q >= IDX_W'(CAPACITY));
  assign sts_o.empty   = (count_q == '0);
  assign sts_o.at_root = (pos_q == IDX_W'(1));
  assign sts_o.no_kid  = (kid > {1'b0, count_q});
  assign sts_o.up_gt   = (rd_a_q > key_q);
  assign sts_o.dn_gt   = (key_q > pick_val);

  always_comb begin
    re      = cmd_i.accept || cmd_i.rd_parent || cmd_i.rd_kids;
    raddr_a = IDX_W'(1);
    raddr_b = count_q;
    if (cmd_i.rd_parent) begin
      raddr_a = parent;
    end else if (cmd_i.rd_kids) begin
      raddr_a = kid[IDX_W-1:0];
      raddr_b = kid_p1[IDX_W-1:0];
    end
    we    = cmd_i.move || cmd_i.place;
    wdata = cmd_i.place ? key_q : (del_q ? pick_val : rd_a_q);
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[pos_q] <= wdata;
    end
    if (re) begin
      rd_a_q <= mem_q[raddr_a];
      rd_b_q <= mem_q[raddr_b];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.accept) begin
      if (op_e'(in_op_i) == OP_INSERT) begin
        if (!sts_o.full) count_q <= count_q + IDX_W'(1);
      end else begin
        if (!sts_o.empty) count_q <= count_q - IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      del_q <= in_op_i;
      key_q <= in_key_i;
      min_q <= '0;
      pos_q <= count_q + IDX_W'(1);
      if (op_e'(in_op_i) == OP_INSERT) begin
        status_q <= sts_o.full ? ST_FULL : ST_OK;
      end else begin
        status_q <= sts_o.empty ? ST_EMPTY : ST_OK;
      end
    end
    if (cmd_i.load_dn) begin
      min_q <= rd_a_q;  // old root
      key_q <= rd_b_q;  // old last entry
      pos_q <= IDX_W'(1);
    end
    if (cmd_i.move) begin
      pos_q <= del_q ? pick_idx : parent;
    end
    if (cmd_i.load_out) begin
      out_min_q    <= min_q;
      out_status_q <= status_q;
      out_count_q  <= COUNT_W'(count_q);
    end
  end

  assign out_min_key_o = out_min_q;
  assign out_status_o  = out_status_q;
  assign out_count_o   = out_count_q;

endmodule

// ===== rtl/binary_min_heap_queue_top.sv =====
// Binary min-heap priority queue of signed 32-bit keys with a stream in and out.
// One item is taken at a time and gives one result item. An insert climbs
// from the new last slot toward the root; a remove takes the old root as the
// result, moves the last entry to the root and sinks it toward a leaf. The
// heap store's reads are registered, so each level is a read step (S_UP or
// S_DN) and a compare-and-write step (S_UP_CMP or S_DN_CMP). A result waits
// in S_FIN while the previous result is still held on the output. An insert
// into a full heap or a remove from an empty one changes nothing and returns
// an error status with a zero key. The next item may be taken while a result
// waits on the output.
module binary_min_heap_queue_top
  import hmq_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // [31:0] key
  input  logic [0:0]  s_axis_tuser,  // [0] cmd
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,  // [31:0] min_key, [38:32] count, [39] zero
  output logic [1:0]  m_axis_tuser   // [1:0] status
);

  dp_cmd_t                    cmd;
  dp_sts_t                    sts;
  logic signed [KEY_W-1:0]    min_key;
  logic        [STATUS_W-1:0] status;
  logic        [COUNT_W-1:0]  count;

  hmq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_op_i     (s_axis_tuser[0]),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  hmq_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .in_op_i       (s_axis_tuser[0]),
    .in_key_i      (s_axis_tdata),
    .out_min_key_o (min_key),
    .out_status_o  (status),
    .out_count_o   (count)
  );

  assign m_axis_tdata = {1'b0, count, min_key};
  assign m_axis_tuser = status;

endmodule

// ===== tb/tb_binary_min_heap_queue_top.sv =====
// Self-checking testbench for the min-heap priority queue: insert and remove streams.
`timescale 1ns / 1ps

module tb_binary_min_heap_queue_top;
  import hmq_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;

  typedef struct {
    logic [KEY_W-1:0]   min_key;
    status_e            status;
    logic [COUNT_W-1:0] count;
  } heap_reply_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;   // [31:0] key
  logic [0:0]  s_axis_tuser = '0;   // [0] cmd
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;        // [31:0] min_key, [38:32] count, [39] zero
  logic [1:0]  m_axis_tuser;        // [1:0] status

  // shadow heap, 1-indexed like the block's store
  logic signed [KEY_W-1:0] heap_keys [1:CAPACITY];
  int unsigned             held_keys = 0;
  heap_reply_t             pending_replies [$];

  int unsigned errors = 0;
  int unsigned cycles = 0;
  int unsigned burst_left = 0;
  int unsigned stall_left = 0;
  int unsigned stall_mode = 0;

  binary_min_heap_queue_top i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, pending_replies.size());
      $display("binary_min_heap_queue_top verification failed");
      $finish;
    end
  end

  // Applies one operation to the shadow heap and returns the result it gives.
  function automatic heap_reply_t apply_heap_op(op_e op, logic signed [KEY_W-1:0] key);
    heap_reply_t             r;
    int unsigned             pos;
    int unsigned             kid;
    logic signed [KEY_W-1:0] tmp;
    logic                    settled;
    r.min_key = '0;
    r.status  = ST_OK;
    if (op == OP_INSERT) begin
      if (held_keys >= CAPACITY) begin
        r.status = ST_FULL;
      end else begin
        held_keys++;
        heap_keys[held_keys] = key;
        pos = held_keys;
        while (pos > 1 && heap_keys[pos/2] > heap_keys[pos]) begin
          tmp = heap_keys[pos/2];
          heap_keys[pos/2] = heap_keys[pos];
          heap_keys[pos] = tmp;
          pos = pos / 2;
        end
      end
    end else begin
      if (held_keys == 0) begin
        r.status = ST_EMPTY;
      end else begin
        r.min_key = heap_keys[1];
        heap_keys[1] = heap_keys[held_keys];
        held_keys--;
        pos = 1;
        kid = 2;
        settled = 1'b0;
        while (!settled && kid <= held_keys) begin
          // right child only when the left is strictly larger
          if (kid + 1 <= held_keys && heap_keys[kid] > heap_keys[kid+1]) kid++;
          if (heap_keys[pos] > heap_keys[kid]) begin
            tmp = heap_keys[pos];
            heap_keys[pos] = heap_keys[kid];
            heap_keys[kid] = tmp;
            pos = kid;
            kid = 2 * pos;
          end else begin
            settled = 1'b1;
          end
        end
      end
    end
    r.count = held_keys[COUNT_W-1:0];
    return r;
  endfunction

  // Random key: mostly full range, some duplicates near zero, some extremes.
  function automatic logic [KEY_W-1:0] pick_key();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0:       return 32'h8000_0000;
          1:       return 32'h7FFF_FFFF;
          2:       return 32'hFFFF_FFFF;
          default: return 32'h0000_0000;
        endcase
      end
      1, 2, 3: return $unsigned($signed($urandom_range(0, 16)) - 8);
      default: return $urandom;
    endcase
  endfunction

  // Sends one item; the sender runs in bursts with random gaps between them.
  task automatic send_item(op_e op, logic [KEY_W-1:0] key);
    if (burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= key;
    s_axis_tuser  <= op;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pending_replies.push_back(apply_heap_op(op, key));
    burst_left--;
    @(negedge clk_i);
  endtask

  task automatic wait_drain();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (pending_replies.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Empty remove, key extremes, equal keys, remove down to empty.
  task automatic test_directed();
    send_item(OP_REMOVE, 32'hFFFF_FFFF);
    send_item(OP_INSERT, 32'h0000_0000);
    send_item(OP_INSERT, 32'h7FFF_FFFF);
    send_item(OP_INSERT, 32'h8000_0000);
    send_item(OP_INSERT, 32'hFFFF_FFFF);
    send_item(OP_INSERT, 32'h0000_0001);
    send_item(OP_INSERT, 32'h0000_0005);
    send_item(OP_INSERT, 32'h0000_0005);
    send_item(OP_INSERT, 32'h0000_0005);
    send_item(OP_INSERT, 32'h8000_0000);
    send_item(OP_REMOVE, 32'h5555_5555);
    send_item(OP_REMOVE, 32'hAAAA_AAAA);
    while (held_keys != 0) send_item(OP_REMOVE, $urandom);
    send_item(OP_REMOVE, 32'h0000_0000);
    send_item(OP_INSERT, 32'h8000_0001);
    send_item(OP_REMOVE, 32'h7FFF_FFFF);
    wait_drain();
  endtask

  // Fill to capacity, push past full, then drain about half.
  task automatic test_fill_full();
    while (held_keys < CAPACITY) send_item(OP_INSERT, pick_key());
    repeat (3) send_item(OP_INSERT, pick_key());
    wait_drain();
    repeat (70) send_item(OP_REMOVE, $urandom);
    wait_drain();
  endtask

  // Mixed stream in segments of differing insert bias to sweep the fill level.
  task automatic test_random_mix(int unsigned n_items);
    int unsigned done_items;
    int unsigned seg_left;
    int unsigned insert_pct;
    done_items = 0;
    seg_left   = 0;
    insert_pct = 50;
    while (done_items < n_items) begin
      if (seg_left == 0) begin
        seg_left = $urandom_range(20, 70);
        case ($urandom_range(0, 2))
          0:       insert_pct = 85;
          1:       insert_pct = 15;
          default: insert_pct = 50;
        endcase
      end
      if ($urandom_range(0, 99) < insert_pct) send_item(OP_INSERT, pick_key());
      else send_item(OP_REMOVE, $urandom);
      seg_left--;
      done_items++;
      if (done_items == n_items / 2) wait_drain();
    end
    wait_drain();
  endtask

  // Receiver stall pattern: always ready, random, or periodic, switching at random.
  always @(negedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      stall_left = $urandom_range(20, 120);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      0:       m_axis_tready <= 1'b1;
      1:       m_axis_tready <= ($urandom_range(0, 3) != 0);
      default: m_axis_tready <= ((cycles % 7) < 3);
    endcase
  end

  always @(posedge clk_i) begin
    heap_reply_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_replies.size() == 0) begin
        $display("%0t: unexpected result tdata=%h tuser=%h", $time, m_axis_tdata, m_axis_tuser);
        errors++;
      end else begin
        want = pending_replies.pop_front();
        if (m_axis_tdata[31:0] !== want.min_key) begin
          $display("%0t: min_key expected %h actual %h", $time, want.min_key,
                   m_axis_tdata[31:0]);
          errors++;
        end
        if (m_axis_tdata[38:32] !== want.count) begin
          $display("%0t: count expected %0d actual %0d", $time, want.count,
                   m_axis_tdata[38:32]);
          errors++;
        end
        if (m_axis_tuser !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, m_axis_tuser);
          errors++;
        end
      end
    end
  end

  initial begin
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed();
    test_fill_full();
    test_random_mix(430);
    repeat (40) @(posedge clk_i);
    if (errors == 0) begin
      $display("binary_min_heap_queue_top verification clean");
    end else begin
      $display("binary_min_heap_queue_top verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/hmq_pkg.sv
rtl/hmq_ctrl.sv
rtl/hmq_dp.sv
rtl/binary_min_heap_queue_top.sv
tb/tb_binary_min_heap_queue_top.sv
